// ===== hw/rtl/transparent_depth_sorter_assert.svh =====
// assertion macros of the transparent depth sorter, used by its datapath module
// expects clk and arst_n in the scope where a macro is used
`ifndef TRANSPARENT_DEPTH_SORTER_ASSERT_SVH
`define TRANSPARENT_DEPTH_SORTER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TDS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define TDS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/tds_pkg.sv =====
// shared types and constants of the transparent depth sorter
// no dependencies
package tds_pkg;

	// parameter defaults
	localparam int MAX_TRANSPARENT_DEF = 32;
	localparam int COORD_BITS_DEF      = 16;

	// fixed field widths
	localparam int ID_W    = 16;
	localparam int FIELD_W = 16;
	localparam int ALPHA_W = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'hFF;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EYE_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EYE_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EYE_Z = 2'd2;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SQ,
		S_INS,
		S_FLUSH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic  take;      // latch the accepted instance
		logic  out_imm;   // load output with the accepted instance
		axis_t axis;      // coordinate fed to the squarer
		logic  acc_load;  // start the distance sum
		logic  acc_add;   // add the next square
		logic  insert;    // insert distance into the sorted row
		logic  pop;       // move row head to output and shift row
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic opaque;     // alpha input is fully opaque
		logic full;       // row holds the maximum count
		logic empty;      // row holds nothing
		logic single;     // row holds exactly one entry
		logic out_valid;  // output register holds a result
	} stat_t;

endpackage

// ===== hw/rtl/tds_ctrl.sv =====
// controller state machine of the transparent depth sorter
// depends on tds_pkg
module tds_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          frame_last,
	input  logic          out_stall,
	input  tds_pkg::stat_t st,
	output logic          in_stall,
	output tds_pkg::cmd_t cmd
);
	import tds_pkg::*;

	// squarer pipe: three coordinates, two register stages before the sum
	localparam logic [2:0] PH_ACC = 3'd2;
	localparam logic [2:0] PH_END = 3'd4;

	state_t     state_q, state_nxt;
	logic [2:0] ph_q;
	logic       last_q;
	logic       out_free;

	assign out_free = !st.out_valid || !out_stall;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// phase counter and frame end flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= '0;
			last_q <= 1'b0;
		end else begin
			if (state_q == S_SQ) begin
				ph_q <= ph_q + 3'd1;
			end else begin
				ph_q <= '0;
			end
			if (cmd.take) begin
				last_q <= frame_last;
			end
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.axis  = AXIS_X;
		in_stall  = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = !out_free;
				if (in_valid && out_free) begin
					cmd.take = 1'b1;
					if (st.opaque || st.full) begin
						cmd.out_imm = 1'b1;
						if (frame_last && !st.empty) begin
							state_nxt = S_FLUSH;
						end
					end else begin
						state_nxt = S_SQ;
					end
				end
			end
			S_SQ: begin
				unique case (ph_q)
					3'd0:    cmd.axis = AXIS_X;
					3'd1:    cmd.axis = AXIS_Y;
					default: cmd.axis = AXIS_Z;
				endcase
				cmd.acc_load = (ph_q == PH_ACC);
				cmd.acc_add  = (ph_q > PH_ACC);
				if (ph_q == PH_END) begin
					state_nxt = S_INS;
				end
			end
			S_INS: begin
				cmd.insert = 1'b1;
				state_nxt  = last_q ? S_FLUSH : S_IDLE;
			end
			S_FLUSH: begin
				if (out_free) begin
					cmd.pop = 1'b1;
					if (st.single) begin
						state_nxt = S_IDLE;
					end
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/tds_dpath.sv =====
// datapath of the transparent depth sorter: eye registers, distance unit,
// sorted register row and output register; depends on tds_pkg and the assert header
module tds_dpath #(
	parameter int MAX_TRANSPARENT = tds_pkg::MAX_TRANSPARENT_DEF,
	parameter int COORD_BITS      = tds_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tds_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tds_pkg::FIELD_W-1:0]   cfg_data,
	input  logic [tds_pkg::ID_W-1:0]      instance_id,
	input  logic [tds_pkg::FIELD_W-1:0]   pos_x,
	input  logic [tds_pkg::FIELD_W-1:0]   pos_y,
	input  logic [tds_pkg::FIELD_W-1:0]   pos_z,
	input  logic [tds_pkg::ALPHA_W-1:0]   alpha,
	input  logic                          frame_last,
	input  logic                          out_stall,
	input  tds_pkg::cmd_t                 cmd,
	output tds_pkg::stat_t                st,
	output logic                          out_valid,
	output logic [tds_pkg::ID_W-1:0]      draw_id,
	output logic                          is_transparent,
	output logic                          unsorted,
	output logic                          frame_done
);
	import tds_pkg::*;

	`include "transparent_depth_sorter_assert.svh"

	localparam int MAG_W  = COORD_BITS + 1;
	localparam int DIST_W = 2 * COORD_BITS + 2;
	localparam int CNT_W  = $clog2(MAX_TRANSPARENT + 1);

	logic [FIELD_W-1:0] eye_x_q, eye_y_q, eye_z_q;
	logic [FIELD_W-1:0] px_q, py_q, pz_q;
	logic [ID_W-1:0]    id_in_q;

	logic [FIELD_W-1:0]          sel_pos, sel_eye;
	logic signed [COORD_BITS:0]  diff;
	logic [MAG_W-1:0]            mag_s1;
	logic [DIST_W-1:0]           sq_s2;
	logic [DIST_W-1:0]           acc_q;

	logic [CNT_W-1:0]  count_q;
	logic [ID_W-1:0]   row_id_q   [MAX_TRANSPARENT];
	logic [DIST_W-1:0] row_dist_q [MAX_TRANSPARENT];
	logic [MAX_TRANSPARENT-1:0] take;

	logic            out_valid_q;
	logic [ID_W-1:0] draw_id_q;
	logic            is_tr_q, uns_q, done_q;

	// field to signed coordinate of COORD_BITS bits
	function automatic logic signed [COORD_BITS:0] to_coord(input logic [FIELD_W-1:0] f);
		logic [COORD_BITS-1:0] c;
		c = COORD_BITS'(f);
		return $signed({c[COORD_BITS-1], c});
	endfunction

	// status
	assign st.opaque    = (alpha == ALPHA_OPAQUE);
	assign st.full      = (count_q == CNT_W'(MAX_TRANSPARENT));
	assign st.empty     = (count_q == '0);
	assign st.single    = (count_q == CNT_W'(1));
	assign st.out_valid = out_valid_q;

	// eye position registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eye_x_q <= '0;
			eye_y_q <= '0;
			eye_z_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EYE_X: eye_x_q <= cfg_data;
				REG_EYE_Y: eye_y_q <= cfg_data;
				REG_EYE_Z: eye_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// accepted instance
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			id_in_q <= instance_id;
			px_q    <= pos_x;
			py_q    <= pos_y;
			pz_q    <= pos_z;
		end
	end

	// coordinate select for the shared squarer
	always_comb begin
		case (cmd.axis)
			AXIS_X: begin
				sel_pos = px_q;
				sel_eye = eye_x_q;
			end
			AXIS_Y: begin
				sel_pos = py_q;
				sel_eye = eye_y_q;
			end
			default: begin
				sel_pos = pz_q;
				sel_eye = eye_z_q;
			end
		endcase
	end

	assign diff = to_coord(sel_pos) - to_coord(sel_eye);

	// magnitude, square, then distance sum
	always_ff @(posedge clk) begin
		mag_s1 <= diff[COORD_BITS] ? MAG_W'(-diff) : MAG_W'(diff);
		sq_s2  <= DIST_W'(mag_s1) * DIST_W'(mag_s1);
		if (cmd.acc_load) begin
			acc_q <= sq_s2;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + sq_s2;
		end
	end

	// an entry takes the new distance when it is empty or strictly nearer
	always_comb begin
		for (int i = 0; i < MAX_TRANSPARENT; i++) begin
			take[i] = (count_q <= CNT_W'(i)) || (row_dist_q[i] < acc_q);
		end
	end

	// sorted row: farthest at the head, insertion shifts toward the tail
	for (genvar g = 0; g < MAX_TRANSPARENT; g++) begin : g_row
		logic              prev_take;
		logic [ID_W-1:0]   prev_id, next_id;
		logic [DIST_W-1:0] prev_dist, next_dist;

		if (g == 0) begin : g_head
			assign prev_take = 1'b0;
			assign prev_id   = '0;
			assign prev_dist = '0;
		end else begin : g_body
			assign prev_take = take[g-1];
			assign prev_id   = row_id_q[g-1];
			assign prev_dist = row_dist_q[g-1];
		end

		if (g == MAX_TRANSPARENT - 1) begin : g_tail
			assign next_id   = row_id_q[g];
			assign next_dist = row_dist_q[g];
		end else begin : g_mid
			assign next_id   = row_id_q[g+1];
			assign next_dist = row_dist_q[g+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.insert) begin
				if (prev_take) begin
					row_id_q[g]   <= prev_id;
					row_dist_q[g] <= prev_dist;
				end else if (take[g]) begin
					row_id_q[g]   <= id_in_q;
					row_dist_q[g] <= acc_q;
				end
			end else if (cmd.pop) begin
				row_id_q[g]   <= next_id;
				row_dist_q[g] <= next_dist;
			end
		end
	end

	// held count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.insert) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_imm || cmd.pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.out_imm) begin
			draw_id_q <= instance_id;
			is_tr_q   <= !st.opaque;
			uns_q     <= !st.opaque;
			done_q    <= frame_last && st.empty;
		end else if (cmd.pop) begin
			draw_id_q <= row_id_q[0];
			is_tr_q   <= 1'b1;
			uns_q     <= 1'b0;
			done_q    <= st.single;
		end
	end

	assign out_valid      = out_valid_q;
	assign draw_id        = draw_id_q;
	assign is_transparent = is_tr_q;
	assign unsorted       = uns_q;
	assign frame_done     = done_q;

	`TDS_ASSERT_SAME(a_insert_not_full, cmd.insert, !st.full, "insert into a full row")
	`TDS_ASSERT_SAME(a_pop_not_empty, cmd.pop, !st.empty, "pop from an empty row")
	`TDS_ASSERT_SAME(a_one_out_load, cmd.out_imm, !cmd.pop, "two output loads at once")
	`TDS_ASSERT_NEXT(a_insert_counts, cmd.insert, count_q == $past(count_q) + CNT_W'(1), "insert count")
	`TDS_ASSERT_SAME(a_load_free, cmd.out_imm || cmd.pop, !out_valid_q || !out_stall, "output overwrite")

endmodule

// ===== hw/rtl/transparent_depth_sorter.sv =====
// Transparent depth sorter, back to front. Opaque instances (alpha 255) and
// instances that find the store full go straight to the output register. A
// transparent instance that is stored has its squared distance to the eye
// built by one shared squarer, one axis per cycle through a three-stage
// magnitude/square/sum pipe, and is then inserted into the sorted register
// row. On the frame's last instance the row drains head first, one result
// per cycle while the output is not stalled; no input is taken until the
// drain ends. Eye registers must be written by the user only while the block
// is idle; the block itself does not enforce this. No clearing pass after reset.
module transparent_depth_sorter #(
	parameter int MAX_TRANSPARENT = tds_pkg::MAX_TRANSPARENT_DEF,
	parameter int COORD_BITS      = tds_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tds_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tds_pkg::FIELD_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [tds_pkg::ID_W-1:0]      instance_id,
	input  logic [tds_pkg::FIELD_W-1:0]   pos_x,
	input  logic [tds_pkg::FIELD_W-1:0]   pos_y,
	input  logic [tds_pkg::FIELD_W-1:0]   pos_z,
	input  logic [tds_pkg::ALPHA_W-1:0]   alpha,
	input  logic                          frame_last,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tds_pkg::ID_W-1:0]      draw_id,
	output logic                          is_transparent,
	output logic                          unsorted,
	output logic                          frame_done
);
	import tds_pkg::*;

	cmd_t  cmd;
	stat_t st;

	// sequencing
	tds_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.frame_last (frame_last),
		.out_stall  (out_stall),
		.st         (st),
		.in_stall   (in_stall),
		.cmd        (cmd)
	);

	// distance, sorted row and output register
	tds_dpath #(
		.MAX_TRANSPARENT (MAX_TRANSPARENT),
		.COORD_BITS      (COORD_BITS)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.instance_id    (instance_id),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.pos_z          (pos_z),
		.alpha          (alpha),
		.frame_last     (frame_last),
		.out_stall      (out_stall),
		.cmd            (cmd),
		.st             (st),
		.out_valid      (out_valid),
		.draw_id        (draw_id),
		.is_transparent (is_transparent),
		.unsorted       (unsorted),
		.frame_done     (frame_done)
	);

endmodule

// ===== dv/depth_order_checker.sv =====
// checker for the transparent depth sorter: watches the eye writes and both channels,
// predicts the draw order of every accepted instance and compares each result transfer
// depends on tds_pkg for widths, the opaque alpha and the register indexes
module depth_order_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tds_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tds_pkg::FIELD_W-1:0]   cfg_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [tds_pkg::ID_W-1:0]      instance_id,
	input  logic [tds_pkg::FIELD_W-1:0]   pos_x,
	input  logic [tds_pkg::FIELD_W-1:0]   pos_y,
	input  logic [tds_pkg::FIELD_W-1:0]   pos_z,
	input  logic [tds_pkg::ALPHA_W-1:0]   alpha,
	input  logic                          frame_last,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [tds_pkg::ID_W-1:0]      draw_id,
	input  logic                          is_transparent,
	input  logic                          unsorted,
	input  logic                          frame_done,
	output int                            mismatches,
	output int                            pending,
	output int                            results_seen
);
	import tds_pkg::*;

	localparam int ROW_DEPTH = MAX_TRANSPARENT_DEF;
	localparam int KEY_W     = 34;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic            transparent;
		logic            early;
		logic            done;
	} draw_t;

	// predicted camera and sorted row, farthest first
	logic signed [FIELD_W-1:0] eye_x, eye_y, eye_z;
	logic [ID_W-1:0]           row_ids  [ROW_DEPTH];
	logic [KEY_W-1:0]          row_keys [ROW_DEPTH];
	int                        row_fill;
	draw_t                     draw_q[$];
	int                        miss_tally;
	int                        seen_tally;

	// append one predicted draw at the tail of the queue
	function automatic void queue_draw(input draw_t d);
		draw_q.insert(draw_q.size(), d);
	endfunction

	// result check first, then eye writes, then prediction of the accepted instance
	always @(posedge clk or negedge arst_n) begin : watch
		draw_t            got;
		draw_t            want;
		draw_t            tail;
		longint           dx, dy, dz;
		logic [KEY_W-1:0] key;
		int               slot;
		int               n_new;
		if (!arst_n) begin
			eye_x = '0;
			eye_y = '0;
			eye_z = '0;
			row_fill = 0;
			draw_q.delete();
			miss_tally = 0;
			seen_tally = 0;
			mismatches <= 0;
			pending <= 0;
			results_seen <= 0;
		end else begin
			// result transfer against the oldest prediction
			if (out_valid && !out_stall) begin
				got = {draw_id, is_transparent, unsorted, frame_done};
				seen_tally++;
				if (draw_q.size() == 0) begin
					if (miss_tally < REPORT_MAX)
						$display("unexpected draw: id %h tr %b uns %b done %b",
							got.id, got.transparent, got.early, got.done);
					miss_tally++;
				end else begin
					want = draw_q.pop_front();
					if (got !== want) begin
						if (miss_tally < REPORT_MAX)
							$display("draw mismatch: expected %h %b%b%b, got %h %b%b%b",
								want.id, want.transparent, want.early, want.done,
								got.id, got.transparent, got.early, got.done);
						miss_tally++;
					end
				end
			end

			// eye register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_EYE_X: eye_x = cfg_data;
					REG_EYE_Y: eye_y = cfg_data;
					REG_EYE_Z: eye_z = cfg_data;
					default: ;
				endcase
			end

			// instance transfer
			if (in_valid && !in_stall) begin
				n_new = 0;
				if (alpha == ALPHA_OPAQUE) begin
					queue_draw(draw_t'{instance_id, 1'b0, 1'b0, 1'b0});
					n_new++;
				end else if (row_fill >= ROW_DEPTH) begin
					queue_draw(draw_t'{instance_id, 1'b1, 1'b1, 1'b0});
					n_new++;
				end else begin
					dx = longint'($signed(pos_x)) - longint'(eye_x);
					dy = longint'($signed(pos_y)) - longint'(eye_y);
					dz = longint'($signed(pos_z)) - longint'(eye_z);
					key = KEY_W'(dx * dx + dy * dy + dz * dz);
					// goes in front of the first nearer entry, behind equal ones
					slot = row_fill;
					for (int i = 0; i < row_fill; i++)
						if (slot == row_fill && row_keys[i] < key)
							slot = i;
					for (int i = row_fill; i > slot; i--) begin
						row_ids[i]  = row_ids[i-1];
						row_keys[i] = row_keys[i-1];
					end
					row_ids[slot]  = instance_id;
					row_keys[slot] = key;
					row_fill++;
				end
				// frame end drains the row back to front
				if (frame_last) begin
					for (int i = 0; i < row_fill; i++) begin
						queue_draw(draw_t'{row_ids[i], 1'b1, 1'b0, 1'b0});
						n_new++;
					end
					row_fill = 0;
					if (n_new > 0) begin
						tail = draw_q[draw_q.size()-1];
						tail.done = 1'b1;
						draw_q[draw_q.size()-1] = tail;
					end
				end
			end

			mismatches <= miss_tally;
			pending <= draw_q.size();
			results_seen <= seen_tally;
		end
	end

endmodule

// ===== dv/tb_transparent_depth_sorter.sv =====
// top of the transparent depth sorter testbench: clock, reset, instance stimulus,
// eye settings, result stall pattern and the verdict
// depends on tds_pkg, transparent_depth_sorter and depth_order_checker
module tb_transparent_depth_sorter;
	import tds_pkg::*;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_BEAT
	} stall_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_EYE_X;
	logic [FIELD_W-1:0]   cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [ID_W-1:0]      instance_id = '0;
	logic [FIELD_W-1:0]   pos_x = '0;
	logic [FIELD_W-1:0]   pos_y = '0;
	logic [FIELD_W-1:0]   pos_z = '0;
	logic [ALPHA_W-1:0]   alpha = '0;
	logic                 frame_last = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [ID_W-1:0]      draw_id;
	logic                 is_transparent;
	logic                 unsorted;
	logic                 frame_done;

	int mismatches;
	int pending;
	int results_seen;

	int burst_left = 0;
	int items_sent = 0;
	int frames_sent = 0;
	int crowd_frames = 0;
	int eye_settings = 1;

	stall_mode_t stall_mode;
	int          stall_left;
	int          stall_tick;

	always #2 clk = ~clk;

	transparent_depth_sorter u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.instance_id    (instance_id),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.pos_z          (pos_z),
		.alpha          (alpha),
		.frame_last     (frame_last),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.draw_id        (draw_id),
		.is_transparent (is_transparent),
		.unsorted       (unsorted),
		.frame_done     (frame_done)
	);

	depth_order_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.instance_id    (instance_id),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.pos_z          (pos_z),
		.alpha          (alpha),
		.frame_last     (frame_last),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.draw_id        (draw_id),
		.is_transparent (is_transparent),
		.unsorted       (unsorted),
		.frame_done     (frame_done),
		.mismatches     (mismatches),
		.pending        (pending),
		.results_seen   (results_seen)
	);

	// result side stall, switching between patterns of random length
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_mode = STALL_NONE;
			stall_left = 0;
			stall_tick = 0;
		end else begin
			if (stall_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				stall_left = $urandom_range(16, 96);
			end
			stall_left--;
			stall_tick++;
			case (stall_mode)
				STALL_NONE:  out_stall <= 1'b0;
				STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
				default:     out_stall <= stall_tick[1];
			endcase
		end
	end

	// one instance transfer, with a random gap at the start of each burst
	task automatic send_instance(input logic [ID_W-1:0] id, input logic [FIELD_W-1:0] x,
		input logic [FIELD_W-1:0] y, input logic [FIELD_W-1:0] z,
		input logic [ALPHA_W-1:0] a, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		instance_id <= id;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		alpha <= a;
		frame_last <= last;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		items_sent++;
		if (last)
			frames_sent++;
	endtask

	// hold the sender until every predicted draw is out, then let the block settle
	task automatic quiesce();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
			guard++;
		end while (pending != 0 && guard < 50000);
		repeat (12) @(posedge clk);
		burst_left = 0;
	endtask

	// new camera position, written while the block is idle
	task automatic set_eye(input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y,
		input logic [FIELD_W-1:0] z);
		quiesce();
		cfg_we <= 1'b1;
		cfg_index <= REG_EYE_X;
		cfg_data <= x;
		@(posedge clk);
		cfg_index <= REG_EYE_Y;
		cfg_data <= y;
		@(posedge clk);
		cfg_index <= REG_EYE_Z;
		cfg_data <= z;
		@(posedge clk);
		cfg_we <= 1'b0;
		eye_settings++;
	endtask

	// frame of random instances; half the coordinates sit on a coarse grid so equal distances are common
	task automatic run_frame(input int n, input int opaque_pct);
		logic [FIELD_W-1:0] p [3];
		logic [ALPHA_W-1:0] a;
		for (int k = 0; k < n; k++) begin
			for (int j = 0; j < 3; j++)
				p[j] = ($urandom_range(0, 1) == 0) ? FIELD_W'($urandom)
					: FIELD_W'(($urandom_range(0, 4) - 2) * 256);
			a = ($urandom_range(0, 99) < opaque_pct) ? ALPHA_OPAQUE
				: ALPHA_W'($urandom_range(0, 254));
			send_instance(ID_W'($urandom), p[0], p[1], p[2], a, k == n - 1);
		end
	endtask

	// frames of mixed size until the quota is met, sometimes draining fully
	task automatic run_phase(input int quota);
		int start;
		int pick;
		start = items_sent;
		while (items_sent - start < quota) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				run_frame($urandom_range(1, 10), 30);
			end else if (pick < 9) begin
				run_frame($urandom_range(11, 31), 15);
			end else begin
				run_frame($urandom_range(33, 40), 5);
				crowd_frames++;
			end
			if ($urandom_range(0, 5) == 0)
				quiesce();
		end
	endtask

	// watchdog
	initial begin
		#2000000;
		$display("tb_transparent_depth_sorter: errors");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// opaque instance alone ends a frame
		send_instance(16'h0000, 16'h0000, 16'h0000, 16'h0000, ALPHA_OPAQUE, 1'b1);
		// lone transparent at the corner of the range, fully clear
		send_instance(16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 8'h00, 1'b1);
		// equal distances keep arrival order, farthest first, opaque last item goes first
		send_instance(16'h0001, 16'h0100, 16'h0000, 16'h0000, 8'h80, 1'b0);
		send_instance(16'h0002, 16'h0000, 16'hFF00, 16'h0000, 8'h80, 1'b0);
		send_instance(16'h0003, 16'h0000, 16'h0000, 16'h0100, 8'h80, 1'b0);
		send_instance(16'h0004, 16'h8000, 16'h8000, 16'h8000, 8'hFE, 1'b0);
		send_instance(16'h0005, 16'h0000, 16'h0000, 16'h0000, 8'h01, 1'b0);
		send_instance(16'h0006, 16'h0000, 16'h0000, 16'h0000, ALPHA_OPAQUE, 1'b1);
		// opaque in the middle of a frame, transparent last item joins the drain
		send_instance(16'h0007, 16'h0200, 16'h0200, 16'h0000, 8'hC8, 1'b0);
		send_instance(16'h0008, 16'h7FFF, 16'h7FFF, 16'h7FFF, ALPHA_OPAQUE, 1'b0);
		send_instance(16'h0009, 16'hFE00, 16'h0200, 16'h0000, 8'h64, 1'b1);
		// store overflow, including on the frame's last instance
		run_frame(36, 0);
		crowd_frames++;

		run_phase(65);
		set_eye(16'h7FFF, 16'h7FFF, 16'h7FFF);
		run_phase(65);
		set_eye(16'h8000, 16'h8000, 16'h8000);
		run_phase(65);
		set_eye(16'h7FFF, 16'h8000, 16'h0000);
		run_phase(65);
		set_eye(FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom));
		run_phase(65);
		quiesce();

		$display("run covered %0d instances in %0d frames, %0d of them past the store size,",
			items_sent, frames_sent, crowd_frames);
		$display("under %0d eye settings, with %0d draws checked", eye_settings, results_seen);
		if (mismatches == 0 && pending == 0)
			$display("tb_transparent_depth_sorter: clean");
		else
			$display("tb_transparent_depth_sorter: errors");
		$finish;
	end

endmodule

// ===== transparent_depth_sorter.f =====
+incdir+hw/rtl
hw/rtl/tds_pkg.sv
hw/rtl/tds_ctrl.sv
hw/rtl/tds_dpath.sv
hw/rtl/transparent_depth_sorter.sv
dv/depth_order_checker.sv
dv/tb_transparent_depth_sorter.sv
